@@ design/escape_sequence_decoder_unit_defines.svh @@
// ============================================================================
// Assertion macros for the escape sequence decoder
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ESD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/esd_pkg.sv @@
// ============================================================================
// Escape sequence decoder package
// Character constants, status codes, queue sizing and the decoded word type.
// ============================================================================
package esd_pkg;

    // Characters recognized by the decoder.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_NOHEX   = 2'd2;

    // Queue between the classifier and the output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified item: one or two result words.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [1:0] status0;
        logic       end0;
        logic [7:0] byte1;
        logic       end1;
    } t_op;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ design/esd_front.sv @@
// ============================================================================
// Escape sequence decoder front end
// Tracks the escape state and turns accepted bytes into queued words as they complete.
// ============================================================================
`include "escape_sequence_decoder_unit_defines.svh"

module esd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_is_last,
    output logic           o_push,
    output esd_pkg::t_op   o_op
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_HEX0   = 3'd2;
    localparam logic [2:0] MODE_HEX1   = 3'd3;
    localparam logic [2:0] MODE_DRAIN  = 3'd4;

    logic [2:0]   r_mode, n_mode;
    logic [3:0]   r_pend, n_pend;
    logic [4:0]   hex;
    logic         op_valid;
    esd_pkg::t_op op;

    assign hex = esd_pkg::hex_decode(i_in_byte);

    // Classify the byte against the current mode.
    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        op_valid = 1'b0;
        op       = '0;
        op.status0 = esd_pkg::ST_OK;
        op.end0  = i_is_last;
        unique case (r_mode)
            MODE_ESC: begin
                op_valid = 1'b1;
                n_mode   = MODE_NORMAL;
                unique case (i_in_byte)
                    esd_pkg::CH_R:      op.byte0 = esd_pkg::CH_CR;
                    esd_pkg::CH_N:      op.byte0 = esd_pkg::CH_LF;
                    esd_pkg::CH_T:      op.byte0 = esd_pkg::CH_TAB;
                    esd_pkg::CH_ZERO:   op.byte0 = esd_pkg::CH_NUL;
                    esd_pkg::CH_BSLASH: op.byte0 = esd_pkg::CH_BSLASH;
                    esd_pkg::CH_DQUOTE: op.byte0 = esd_pkg::CH_DQUOTE;
                    esd_pkg::CH_X: begin
                        if (i_is_last) begin
                            op.status0 = esd_pkg::ST_NOHEX;
                            op.end0    = 1'b1;
                        end else begin
                            op_valid = 1'b0;
                            n_mode   = MODE_HEX0;
                        end
                    end
                    default: begin
                        op.status0 = esd_pkg::ST_UNKNOWN;
                        op.end0    = 1'b1;
                        n_mode     = i_is_last ? MODE_NORMAL : MODE_DRAIN;
                    end
                endcase
            end
            MODE_HEX0: begin
                if (!hex[4]) begin
                    op_valid   = 1'b1;
                    op.status0 = esd_pkg::ST_NOHEX;
                    op.end0    = 1'b1;
                    n_mode     = i_is_last ? MODE_NORMAL : MODE_DRAIN;
                end else if (i_is_last) begin
                    op_valid = 1'b1;
                    op.byte0 = {4'd0, hex[3:0]};
                    n_mode   = MODE_NORMAL;
                end else begin
                    n_pend = hex[3:0];
                    n_mode = MODE_HEX1;
                end
            end
            MODE_HEX1: begin
                op_valid = 1'b1;
                if (hex[4]) begin
                    op.byte0 = {r_pend, hex[3:0]};
                    n_mode   = MODE_NORMAL;
                end else begin
                    // A single digit ended by another byte: emit it, then
                    // treat the byte as plain text unless it opens an escape.
                    op.byte0 = {4'd0, r_pend};
                    op.end0  = 1'b0;
                    if (i_in_byte == esd_pkg::CH_BSLASH && !i_is_last) begin
                        n_mode = MODE_ESC;
                    end else begin
                        op.two   = 1'b1;
                        op.byte1 = i_in_byte;
                        op.end1  = i_is_last;
                        n_mode   = MODE_NORMAL;
                    end
                end
            end
            MODE_DRAIN: begin
                if (i_is_last) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                if (i_in_byte == esd_pkg::CH_BSLASH && !i_is_last) begin
                    n_mode = MODE_ESC;
                end else begin
                    op_valid = 1'b1;
                    op.byte0 = i_in_byte;
                    n_mode   = MODE_NORMAL;
                end
            end
        endcase
    end

    // Mode and pending digit advance only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_pend <= 4'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
        end
    end

    assign o_push = i_accept && op_valid;
    assign o_op   = op;

    `ESD_ASSERT_NOW(a_drain_silent, r_mode == MODE_DRAIN, !o_push, "word pushed while draining")
    `ESD_ASSERT_NOW(a_error_ends, o_push && o_op.status0 != esd_pkg::ST_OK, o_op.end0 && !o_op.two && o_op.byte0 == 8'd0, "error word not final")

endmodule

@@ design/esd_queue.sv @@
// ============================================================================
// Escape sequence decoder word queue
// Small register queue that decouples the classifier from the output stage.
// ============================================================================
`include "escape_sequence_decoder_unit_defines.svh"

module esd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  esd_pkg::t_op   i_op,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output esd_pkg::t_op   o_head
);

    localparam logic [esd_pkg::QPTR_W-1:0] PTR_LAST = esd_pkg::QPTR_W'(esd_pkg::QDEPTH - 1);
    localparam logic [esd_pkg::QCNT_W-1:0] CNT_FULL = esd_pkg::QCNT_W'(esd_pkg::QDEPTH);

    esd_pkg::t_op                r_mem [esd_pkg::QDEPTH];
    logic [esd_pkg::QPTR_W-1:0]  r_wr, r_rd;
    logic [esd_pkg::QCNT_W-1:0]  r_count;

    // Storage writes; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    `ESD_ASSERT_NOW(a_no_overflow, i_push, !o_full, "push into full queue")
    `ESD_ASSERT_NOW(a_no_underflow, i_pop, !o_empty, "pop from empty queue")

endmodule

@@ design/esd_back.sv @@
// ============================================================================
// Escape sequence decoder output stage
// Expands queued words into one or two results behind an output register.
// ============================================================================
`include "escape_sequence_decoder_unit_defines.svh"

module esd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  esd_pkg::t_op   i_head,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic [1:0]     o_status,
    output logic           o_run_last,
    output logic           o_string_end
);

    logic       r_valid;
    logic       r_second;
    logic [7:0] r_byte;
    logic [1:0] r_status;
    logic       r_run_last;
    logic       r_end;
    logic       load;

    // The output register may take a new result when empty or being taken.
    assign load  = (!r_valid || !i_out_stall) && !i_empty;
    assign o_pop = load && (r_second || !i_head.two);

    // Control: valid flag and the second-half marker of a two-result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= !r_second && i_head.two;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_second) begin
                r_byte     <= i_head.byte1;
                r_status   <= esd_pkg::ST_OK;
                r_run_last <= 1'b1;
                r_end      <= i_head.end1;
            end else begin
                r_byte     <= i_head.byte0;
                r_status   <= i_head.status0;
                r_run_last <= !i_head.two;
                r_end      <= i_head.end0;
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_status     = r_status;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_end;

    `ESD_ASSERT_NOW(a_second_after_first, r_second, r_valid && !r_run_last && !r_end, "second half without first")
    `ESD_ASSERT_NEXT(a_stall_holds, r_valid && i_out_stall, r_valid && $stable(r_byte), "stalled result changed")

endmodule

@@ design/escape_sequence_decoder_unit.sv @@
// ============================================================================
// Escape sequence decoder unit
// Byte-serial decoder for backslash escapes in a text stream.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_in_byte, i_is_last
//  output    out        o_out_valid / i_out_stall o_out_byte, o_status,
//                                                 o_run_last, o_string_end
//
// One byte is accepted per cycle while the queue is not full; the classifier's
// next mode is computed combinationally from its mode register. A byte's first
// result reaches the output through the queue and then the output register. A
// byte that yields two results holds the output register for both in turn, so
// the four-word queue absorbs the difference.
// Reset clears the decoding mode, the queue pointers and the output valid.
// o_in_stall rises only while the queue is full; i_out_stall backs up the queue.

module escape_sequence_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_run_last,
    output logic       o_string_end
);

    logic         accept;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;
    esd_pkg::t_op op;
    esd_pkg::t_op head;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    esd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_is_last (i_is_last),
        .o_push    (push),
        .o_op      (op)
    );

    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    esd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule
